// ===== rtl/palette_flash_engine_defines.svh =====
// palette_flash_engine_defines.svh: assertion macros used by palette_flash_engine
// no dependencies; taken in by `include where a module asserts
`ifndef PALETTE_FLASH_ENGINE_DEFINES_SVH
`define PALETTE_FLASH_ENGINE_DEFINES_SVH

// same-cycle implication, checked at every rising edge outside reset
`define PFE_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PFE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/pfe_pkg.sv =====
// pfe_pkg: sizes, command codes and shared types of the palette flash engine
// no dependencies; imported by pfe_div and palette_flash_engine
`default_nettype none

package pfe_pkg;

   localparam int ENTRIES     = 32;
   localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int IDX_FIELD_W = 5;
   localparam int CH_W        = 5;
   localparam int COLOR_W     = 3 * CH_W;
   localparam int RAMP_W      = 7;
   localparam int TF_W        = 8;
   localparam int CMD_W       = 2;
   localparam int TDATA_W     = 24;
   localparam int PAD_W       = TDATA_W - COLOR_W - IDX_FIELD_W;
   localparam int DIV_CNT_W   = $clog2(CH_W);

   localparam logic [CH_W-1:0] CH_MAX    = '1;
   localparam logic [TF_W-1:0] TF_RESET  = TF_W'(16);

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE = 2'd0,
      CMD_START = 2'd1,
      CMD_TICK  = 2'd2
   } cmd_type;

   typedef struct packed {
      logic            done;
      logic [CH_W-1:0] quo;
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== rtl/palette_flash_engine.sv =====
// palette_flash_engine: fade-to-white flash over a palette, top level
// depends on pfe_pkg, pfe_div and palette_flash_engine_defines.svh
//
//   group  dir  beat payload
//   req_   in   tuser: command; tdata: entry_index, entry_color
//   rsp_   out  tdata: out_index, out_color; tlast: last entry of the tick
//   csr_   in   wdata: flash_frames, written when csr_we is high
//
// a write or an ignored command leaves the engine idle; req_tready is low until the walk or tick ends
// a start walks all entries through the shared divider, three channels each:
//   read the entry, save it, then divide the headroom of each channel by the ramp
// an active tick reads, updates and sends each entry, and stalls while rsp_tready is low
// reset is synchronous; the palette reads as zero until an entry is written
`default_nettype none

module palette_flash_engine (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   input  wire [pfe_pkg::CMD_W-1:0]   req_tuser,   // command
   input  wire [pfe_pkg::TDATA_W-1:0] req_tdata,   // entry_index, entry_color, zero pad
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   output logic [pfe_pkg::TDATA_W-1:0] rsp_tdata,  // out_index, out_color, zero pad
   output logic                       rsp_tlast,
   input  wire                        csr_we,
   input  wire [pfe_pkg::TF_W-1:0]    csr_wdata    // flash_frames
);
   import pfe_pkg::*;
`include "palette_flash_engine_defines.svh"

   typedef enum logic [2:0] {
      S_IDLE,
      S_ST_RD,
      S_ST_SAVE,
      S_ST_DIV,
      S_TK_RD,
      S_TK_CALC,
      S_TK_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_UP,
      PH_DOWN
   } phase_type;

   state_type          state_ff,     state_in;
   phase_type          phase_ff,     phase_in;
   logic [RAMP_W-1:0]  frame_cnt_ff, frame_cnt_in;
   logic [RAMP_W-1:0]  ramp_ff,      ramp_in;
   logic [TF_W-1:0]    tf_ff,        tf_in;
   logic [IDX_W-1:0]   idx_ff,       idx_in;
   logic               up_ff,        up_in;
   logic               fin_ff,       fin_in;
   logic [1:0]         ch_sel_ff,    ch_sel_in;
   logic [COLOR_W-1:0] cur_ff,       cur_in;
   logic [COLOR_W-1:0] step_acc_ff,  step_acc_in;
   logic               div_go_ff,    div_go_in;
   logic [CH_W-1:0]    div_num_ff,   div_num_in;
   logic [COLOR_W-1:0] out_color_ff, out_color_in;
   logic               last_ff,      last_in;
   logic [ENTRIES-1:0] pal_vld_ff,   pal_vld_in;

   // memories and their registered read data
   logic [COLOR_W-1:0] pal_mem   [ENTRIES];
   logic [COLOR_W-1:0] saved_mem [ENTRIES];
   logic [COLOR_W-1:0] step_mem  [ENTRIES];
   logic [COLOR_W-1:0] pal_rd_ff;
   logic               pal_rd_vld_ff;
   logic [COLOR_W-1:0] saved_rd_ff;
   logic [COLOR_W-1:0] step_rd_ff;

   logic               pal_we;
   logic [IDX_W-1:0]   pal_waddr;
   logic [COLOR_W-1:0] pal_wdata;
   logic               saved_we;
   logic               step_we;
   logic [COLOR_W-1:0] step_wdata;

   logic                 req_beat;
   logic [IDX_FIELD_W-1:0] req_index;
   logic [COLOR_W-1:0]   req_color;
   logic [RAMP_W-1:0]    ramp_req;
   logic [RAMP_W-1:0]    frame_cnt_inc;
   logic                 idx_last;
   logic [COLOR_W-1:0]   pal_cur;
   logic [COLOR_W-1:0]   tick_color;
   div_rsp_type          div_rsp;

   function automatic logic [CH_W-1:0] headroom(input logic [COLOR_W-1:0] color,
                                                input logic [1:0] sel);
      logic [CH_W-1:0] ch;
      unique case (sel)
         2'd2:    ch = color[3*CH_W-1:2*CH_W];
         2'd1:    ch = color[2*CH_W-1:CH_W];
         default: ch = color[CH_W-1:0];
      endcase
      return CH_MAX - ch;
   endfunction

   pfe_div u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go_ff),
      .num   (div_num_ff),
      .den   (ramp_ff),
      .rsp   (div_rsp)
   );

   assign req_tready    = (state_ff == S_IDLE);
   assign req_beat      = req_tvalid && req_tready;
   assign req_index     = req_tdata[IDX_FIELD_W-1:0];
   assign req_color     = req_tdata[IDX_FIELD_W+COLOR_W-1:IDX_FIELD_W];
   assign ramp_req      = tf_ff[TF_W-1:1];
   assign frame_cnt_inc = frame_cnt_ff + 1'b1;
   assign idx_last      = (idx_ff == IDX_W'(ENTRIES - 1));
   assign pal_cur       = pal_rd_vld_ff ? pal_rd_ff : '0;
   // packed add or subtract, carries and borrows cross channels on purpose
   assign tick_color    = fin_ff ? saved_rd_ff :
                          (up_ff ? pal_cur + step_rd_ff : pal_cur - step_rd_ff);

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      frame_cnt_in = frame_cnt_ff;
      ramp_in      = ramp_ff;
      tf_in        = csr_we ? csr_wdata : tf_ff;
      idx_in       = idx_ff;
      up_in        = up_ff;
      fin_in       = fin_ff;
      ch_sel_in    = ch_sel_ff;
      cur_in       = cur_ff;
      step_acc_in  = step_acc_ff;
      div_go_in    = 1'b0;
      div_num_in   = div_num_ff;
      out_color_in = out_color_ff;
      last_in      = last_ff;
      pal_we       = 1'b0;
      pal_waddr    = idx_ff;
      pal_wdata    = tick_color;
      saved_we     = 1'b0;
      step_we      = 1'b0;
      step_wdata   = {step_acc_ff[COLOR_W-CH_W-1:0], div_rsp.quo};

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               priority if (req_tuser == CMD_WRITE) begin
                  pal_waddr = IDX_W'(req_index);
                  pal_wdata = req_color;
                  pal_we    = (32'(req_index) < ENTRIES);
               end else if (req_tuser == CMD_START) begin
                  if (phase_ff == PH_IDLE && ramp_req != '0) begin
                     ramp_in      = ramp_req;
                     frame_cnt_in = '0;
                     phase_in     = PH_UP;
                     idx_in       = '0;
                     state_in     = S_ST_RD;
                  end
               end else if (req_tuser == CMD_TICK) begin
                  if (phase_ff != PH_IDLE) begin
                     up_in  = (phase_ff == PH_UP);
                     fin_in = 1'b0;
                     if (frame_cnt_inc >= ramp_ff) begin
                        frame_cnt_in = '0;
                        if (phase_ff == PH_UP) begin
                           phase_in = PH_DOWN;
                        end else begin
                           phase_in = PH_IDLE;
                           fin_in   = 1'b1;
                        end
                     end else begin
                        frame_cnt_in = frame_cnt_inc;
                     end
                     idx_in   = '0;
                     state_in = S_TK_RD;
                  end
               end else begin
                  // unused command code, dropped
               end
            end
         end
         S_ST_RD: begin
            state_in = S_ST_SAVE;
         end
         S_ST_SAVE: begin
            saved_we   = 1'b1;
            cur_in     = pal_cur;
            ch_sel_in  = 2'd2;
            div_num_in = headroom(pal_cur, 2'd2);
            div_go_in  = 1'b1;
            state_in   = S_ST_DIV;
         end
         S_ST_DIV: begin
            if (div_rsp.done) begin
               step_acc_in = step_wdata;
               if (ch_sel_ff == 2'd0) begin
                  step_we = 1'b1;
                  if (idx_last) begin
                     state_in = S_IDLE;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = S_ST_RD;
                  end
               end else begin
                  ch_sel_in  = ch_sel_ff - 1'b1;
                  div_num_in = headroom(cur_ff, ch_sel_ff - 1'b1);
                  div_go_in  = 1'b1;
               end
            end
         end
         S_TK_RD: begin
            state_in = S_TK_CALC;
         end
         S_TK_CALC: begin
            pal_we       = 1'b1;
            out_color_in = tick_color;
            last_in      = idx_last;
            state_in     = S_TK_OUT;
         end
         S_TK_OUT: begin
            if (rsp_tready) begin
               if (idx_last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_TK_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      pal_vld_in = pal_vld_ff;
      if (pal_we) begin
         pal_vld_in[pal_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      up_ff        <= up_in;
      fin_ff       <= fin_in;
      ch_sel_ff    <= ch_sel_in;
      cur_ff       <= cur_in;
      step_acc_ff  <= step_acc_in;
      div_num_ff   <= div_num_in;
      out_color_ff <= out_color_in;
      last_ff      <= last_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_IDLE;
         frame_cnt_ff <= '0;
         ramp_ff      <= '0;
         tf_ff        <= TF_RESET;
         div_go_ff    <= 1'b0;
         pal_vld_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         frame_cnt_ff <= frame_cnt_in;
         ramp_ff      <= ramp_in;
         tf_ff        <= tf_in;
         div_go_ff    <= div_go_in;
         pal_vld_ff   <= pal_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pal_we) begin
         pal_mem[pal_waddr] <= pal_wdata;
      end
      pal_rd_ff     <= pal_mem[idx_ff];
      pal_rd_vld_ff <= pal_vld_ff[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (saved_we) begin
         saved_mem[idx_ff] <= pal_cur;
      end
      saved_rd_ff <= saved_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (step_we) begin
         step_mem[idx_ff] <= step_wdata;
      end
      step_rd_ff <= step_mem[idx_ff];
   end

   assign rsp_tvalid = (state_ff == S_TK_OUT);
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {PAD_W'(0), out_color_ff, IDX_FIELD_W'(idx_ff)};

   `PFE_ASSERT_SAME(a_busy_while_beat, clock, reset, rsp_tvalid, !req_tready,
      "input taken while a result beat is pending")
   `PFE_ASSERT_NEXT(a_idle_after_last, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast,
      req_tready, "not ready after the last beat of a tick")
   `PFE_ASSERT_SAME(a_frame_in_ramp, clock, reset, phase_ff != PH_IDLE,
      (ramp_ff != '0) && (frame_cnt_ff < ramp_ff), "frame count outside the ramp")
   `PFE_ASSERT_SAME(a_div_only_in_walk, clock, reset, div_go_ff, state_ff == S_ST_DIV,
      "divider launched outside the step walk")

endmodule

`default_nettype wire

// ===== rtl/pfe_div.sv =====
// pfe_div: restoring divider, one quotient bit per cycle, for the step table
// depends on pfe_pkg
`default_nettype none

module pfe_div (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      go,
   input  wire [pfe_pkg::CH_W-1:0]  num,
   input  wire [pfe_pkg::RAMP_W-1:0] den,
   output pfe_pkg::div_rsp_type     rsp
);
   import pfe_pkg::*;

   logic [RAMP_W-1:0]    rem_ff,  rem_in;
   logic [CH_W-1:0]      quo_ff,  quo_in;
   logic [RAMP_W-1:0]    den_ff,  den_in;
   logic [DIV_CNT_W-1:0] cnt_ff,  cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [RAMP_W:0] trial;
   logic [RAMP_W:0] diff;
   logic            fits;

   // shift the next numerator bit into the partial remainder
   assign trial = {rem_ff, quo_ff[CH_W-1]};
   assign fits  = (trial >= {1'b0, den_ff});
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (go) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[RAMP_W-1:0] : trial[RAMP_W-1:0];
         quo_in = {quo_ff[CH_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(CH_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule

`default_nettype wire
